FILE: rtl/dpwp_pkg.sv
`timescale 1ns / 1ps

package dpwp_pkg;

	// Default widths of the pixel coordinates and of the depth
	localparam int COORD_BITS_DEF = 12;
	localparam int DEPTH_BITS_DEF = 16;

	// Configuration register map
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PRINCIPAL_POINT = 3'd0,
		REG_INVERSE_FOCAL   = 3'd1,
		REG_DEPTH_WINDOW    = 3'd2,
		REG_POSE_ROW_X      = 3'd3,
		REG_POSE_ROW_Y      = 3'd4,
		REG_POSE_ROW_Z      = 3'd5
	} cfg_reg_t;

	// Register values after reset: centered optics, identity pose
	localparam logic [31:0] PRINCIPAL_POINT_RST = 32'h0EF8_13F8;
	localparam logic [47:0] INVERSE_FOCAL_RST   = 48'h007CD5_007CD5;
	localparam logic [31:0] DEPTH_WINDOW_RST    = 32'hFFFF_0000;
	localparam logic [63:0] POSE_ROW_X_RST      = 64'h0000_0000_0000_4000;
	localparam logic [63:0] POSE_ROW_Y_RST      = 64'h0000_0000_4000_0000;
	localparam logic [63:0] POSE_ROW_Z_RST      = 64'h0000_4000_0000_0000;

	// Fixed-point formats
	localparam int INV_BITS      = 24;  // Q0.24 inverse focal length
	localparam int CAM_DROP      = 20;  // Q.4 * Q0.24 -> Q.8
	localparam int CAM_MAG_BITS  = 40;  // camera coordinate magnitude limit
	localparam int WORLD_FRAC    = 22;  // Q.14 rotation times Q.8 camera
	localparam int TRANS_SHIFT   = 22;
	localparam int COLOR_BITS    = 24;
	localparam int WORLD_BITS    = 16;

	localparam logic [63:0] CAM_LIMIT = (64'd1 << CAM_MAG_BITS) - 64'd1;

endpackage

FILE: rtl/depth_pixel_to_world_point.sv
`timescale 1ns / 1ps

// Depth pixel to world point.
// Slave side takes one depth pixel per word: column, row, depth in mm and
// its sampled color. Pixels whose depth is at or below the window minimum or
// at or above the window maximum are dropped and give no output word.
// Every other pixel is back-projected through the pinhole model and moved by
// the rigid pose; the master side carries world x, y, z in mm (rounded,
// saturated to 16-bit signed) and the color unchanged.
// Throughput is one word per clock while the master side is not stalled.
// A point passes through ten pipeline stages (subtract, magnitude, depth
// multiply, split inverse-focal multiply, round, clamp, sign, pose
// multiplies, two adder levels) and then the output register.
// When the receiver stalls, the next finished point parks in a one-word skid
// register; s_tready drops while it is occupied and the whole pipeline holds.
// Reset (arst_n low) empties the pipeline and loads the identity pose,
// centered principal point and full depth window. Configuration is to be
// written through cfg_wr_en / cfg_index / cfg_wdata while no pixel is in
// flight; the block itself does not enforce this.
module depth_pixel_to_world_point #(
	parameter int COORD_BITS = dpwp_pkg::COORD_BITS_DEF,
	parameter int DEPTH_BITS = dpwp_pkg::DEPTH_BITS_DEF,
	parameter int IN_W = (((2 * COORD_BITS + DEPTH_BITS + 24) + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_wr_en,
	input  logic [dpwp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dpwp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// pixel stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// pixel_column, pixel_row, depth_mm, red, green, blue, zero fill
	input  logic [IN_W-1:0]               s_tdata,
	// point stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// world_x, world_y, world_z, point_red, point_green, point_blue
	output logic [71:0]                   m_tdata
);

	import dpwp_pkg::*;

	localparam int MAG_W  = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
	localparam int OFF_W  = MAG_W + 1;
	localparam int P_W    = MAG_W + DEPTH_BITS;
	localparam int PL_W   = P_W / 2;
	localparam int PH_W   = P_W - PL_W;
	localparam int SUM_W  = P_W + INV_BITS;
	localparam int RW     = SUM_W - CAM_DROP;
	localparam int MAGC_W = (RW > CAM_MAG_BITS) ? CAM_MAG_BITS : RW;
	localparam int XC_W   = MAGC_W + 1;
	localparam int XL_W   = XC_W / 2;
	localparam int XH_W   = XC_W - XL_W;
	localparam int TX_W   = XC_W + 16;
	localparam int TZ_W   = ((DEPTH_BITS + 25 > 38) ? DEPTH_BITS + 25 : 38) + 1;
	localparam int S_W    = ((TX_W > TZ_W) ? TX_W : TZ_W) + 2;
	localparam int M_W    = S_W - WORLD_FRAC;
	localparam int DCMP_W = (DEPTH_BITS > 16) ? DEPTH_BITS : 16;
	localparam int D_LSB  = 2 * COORD_BITS;
	localparam int C_LSB  = 2 * COORD_BITS + DEPTH_BITS;

	localparam logic signed [M_W-1:0] WORLD_MAX = M_W'(32767);
	localparam logic signed [M_W-1:0] WORLD_MIN = -M_W'(32768);

	// Configuration registers
	logic [31:0] principal_q;
	logic [47:0] inv_focal_q;
	logic [31:0] window_q;
	logic [63:0] pose_q [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			principal_q <= PRINCIPAL_POINT_RST;
			inv_focal_q <= INVERSE_FOCAL_RST;
			window_q    <= DEPTH_WINDOW_RST;
			pose_q[0]   <= POSE_ROW_X_RST;
			pose_q[1]   <= POSE_ROW_Y_RST;
			pose_q[2]   <= POSE_ROW_Z_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PRINCIPAL_POINT: principal_q <= cfg_wdata[31:0];
				REG_INVERSE_FOCAL:   inv_focal_q <= cfg_wdata[47:0];
				REG_DEPTH_WINDOW:    window_q    <= cfg_wdata[31:0];
				REG_POSE_ROW_X:      pose_q[0]   <= cfg_wdata;
				REG_POSE_ROW_Y:      pose_q[1]   <= cfg_wdata;
				REG_POSE_ROW_Z:      pose_q[2]   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Per-axis camera constants: lane 0 is x, lane 1 is y
	logic [15:0]         center [0:1];
	logic [INV_BITS-1:0] inv    [0:1];

	always_comb begin
		center[0] = principal_q[15:0];
		center[1] = principal_q[31:16];
		inv[0]    = inv_focal_q[23:0];
		inv[1]    = inv_focal_q[47:24];
	end

	// Unpack the input word
	logic [COORD_BITS-1:0] in_coord [0:1];
	logic [DEPTH_BITS-1:0] in_depth;
	logic [COLOR_BITS-1:0] in_color;
	logic                  in_window;

	always_comb begin
		in_coord[0] = s_tdata[COORD_BITS-1:0];
		in_coord[1] = s_tdata[COORD_BITS +: COORD_BITS];
		in_depth    = s_tdata[D_LSB +: DEPTH_BITS];
		in_color    = s_tdata[C_LSB +: COLOR_BITS];
		in_window   = (DCMP_W'(in_depth) > DCMP_W'(window_q[15:0])) &&
		              (DCMP_W'(in_depth) < DCMP_W'(window_q[31:16]));
	end

	// Pipeline advances unless the skid register holds a word
	logic skid_valid_q;
	logic en;

	assign en       = !skid_valid_q;
	assign s_tready = en;

	// Stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
		end else if (en) begin
			v_s1  <= s_tvalid && in_window;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// Camera-space payload, two lanes
	logic signed [OFF_W-1:0]     off_s1   [0:1];
	logic                        neg_s2   [0:1];
	logic [MAG_W-1:0]            mag_s2   [0:1];
	logic                        neg_s3   [0:1];
	logic [P_W-1:0]              p_s3     [0:1];
	logic                        neg_s4   [0:1];
	logic [PL_W+INV_BITS-1:0]    pl_s4    [0:1];
	logic [PH_W+INV_BITS-1:0]    ph_s4    [0:1];
	logic                        neg_s5   [0:1];
	logic [RW-1:0]               r_s5     [0:1];
	logic                        neg_s6   [0:1];
	logic [MAGC_W-1:0]           magc_s6  [0:1];
	logic signed [XC_W-1:0]      cam_s7   [0:1];

	logic [DEPTH_BITS-1:0] d_s1, d_s2, d_s3, d_s4, d_s5, d_s6, d_s7;
	logic [COLOR_BITS-1:0] c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7, c_s8, c_s9, c_s10;

	// Round and clamp helpers for stages five and six
	logic [SUM_W-1:0] sum_c [0:1];
	logic             sat_c [0:1];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			sum_c[l] = (SUM_W'(ph_s4[l]) << PL_W) + SUM_W'(pl_s4[l]) +
			           (SUM_W'(1) << (CAM_DROP - 1));
			sat_c[l] = 64'(r_s5[l]) > CAM_LIMIT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				// subtract the principal point in Q.4
				off_s1[l]  <= $signed(OFF_W'({in_coord[l], 4'b0000})) -
				              $signed(OFF_W'(center[l]));
				// take sign and magnitude
				neg_s2[l]  <= off_s1[l][OFF_W-1];
				mag_s2[l]  <= off_s1[l][OFF_W-1] ? MAG_W'(-off_s1[l]) : MAG_W'(off_s1[l]);
				// scale by depth
				neg_s3[l]  <= neg_s2[l];
				p_s3[l]    <= P_W'(mag_s2[l]) * P_W'(d_s2);
				// split product with the inverse focal length
				neg_s4[l]  <= neg_s3[l];
				pl_s4[l]   <= (PL_W + INV_BITS)'(p_s3[l][PL_W-1:0]) *
				              (PL_W + INV_BITS)'(inv[l]);
				ph_s4[l]   <= (PH_W + INV_BITS)'(p_s3[l][P_W-1:PL_W]) *
				              (PH_W + INV_BITS)'(inv[l]);
				// recombine and round to Q.8
				neg_s5[l]  <= neg_s4[l];
				r_s5[l]    <= sum_c[l][SUM_W-1:CAM_DROP];
				// clamp the magnitude
				neg_s6[l]  <= neg_s5[l];
				magc_s6[l] <= sat_c[l] ? CAM_LIMIT[MAGC_W-1:0] : r_s5[l][MAGC_W-1:0];
				// restore the sign
				cam_s7[l]  <= neg_s6[l] ? -$signed({1'b0, magc_s6[l]}) :
				              $signed({1'b0, magc_s6[l]});
			end
			d_s1 <= in_depth;
			d_s2 <= d_s1;
			d_s3 <= d_s2;
			d_s4 <= d_s3;
			d_s5 <= d_s4;
			d_s6 <= d_s5;
			d_s7 <= d_s6;
			c_s1 <= in_color;
			c_s2 <= c_s1;
			c_s3 <= c_s2;
			c_s4 <= c_s3;
			c_s5 <= c_s4;
			c_s6 <= c_s5;
			c_s7 <= c_s6;
			c_s8 <= c_s7;
			c_s9 <= c_s8;
			c_s10 <= c_s9;
		end
	end

	// World-space payload, one lane per pose row
	logic signed [XL_W+16:0]  pxl_s8 [0:2];
	logic signed [XH_W+15:0]  pxh_s8 [0:2];
	logic signed [XL_W+16:0]  pyl_s8 [0:2];
	logic signed [XH_W+15:0]  pyh_s8 [0:2];
	logic signed [DEPTH_BITS+16:0] pz_s8 [0:2];
	logic signed [TX_W-1:0]   tx_s9  [0:2];
	logic signed [TX_W-1:0]   ty_s9  [0:2];
	logic signed [TZ_W-1:0]   tz_s9  [0:2];
	logic signed [S_W-1:0]    s_s10  [0:2];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				// rotation products, camera x and y split in halves
				pxl_s8[k] <= $signed(pose_q[k][15:0]) *
				             $signed({1'b0, cam_s7[0][XL_W-1:0]});
				pxh_s8[k] <= $signed(pose_q[k][15:0]) * $signed(cam_s7[0][XC_W-1:XL_W]);
				pyl_s8[k] <= $signed(pose_q[k][31:16]) *
				             $signed({1'b0, cam_s7[1][XL_W-1:0]});
				pyh_s8[k] <= $signed(pose_q[k][31:16]) * $signed(cam_s7[1][XC_W-1:XL_W]);
				pz_s8[k]  <= $signed(pose_q[k][47:32]) * $signed({1'b0, d_s7});
				// recombine halves; add translation and rounding bias
				tx_s9[k]  <= (TX_W'(pxh_s8[k]) <<< XL_W) + TX_W'(pxl_s8[k]);
				ty_s9[k]  <= (TX_W'(pyh_s8[k]) <<< XL_W) + TX_W'(pyl_s8[k]);
				tz_s9[k]  <= (TZ_W'(pz_s8[k]) <<< 8) +
				             (TZ_W'($signed(pose_q[k][63:48])) <<< TRANS_SHIFT) +
				             TZ_W'(2 ** (WORLD_FRAC - 1));
				// final sum in Q.22
				s_s10[k]  <= S_W'(tx_s9[k]) + S_W'(ty_s9[k]) + S_W'(tz_s9[k]);
			end
		end
	end

	// Drop the fraction and saturate to 16 bits
	logic signed [M_W-1:0]        m_c     [0:2];
	logic [WORLD_BITS-1:0]        world_c [0:2];
	logic [71:0]                  push_data;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			m_c[k] = $signed(s_s10[k][S_W-1:WORLD_FRAC]);
			if (m_c[k] > WORLD_MAX) begin
				world_c[k] = 16'h7FFF;
			end else if (m_c[k] < WORLD_MIN) begin
				world_c[k] = 16'h8000;
			end else begin
				world_c[k] = m_c[k][WORLD_BITS-1:0];
			end
		end
		push_data = {c_s10[23:16], c_s10[15:8], c_s10[7:0],
		             world_c[2], world_c[1], world_c[0]};
	end

	// Output register with one-word skid
	logic        out_valid_q;
	logic [71:0] out_data_q;
	logic [71:0] skid_data_q;
	logic        push;

	assign push = en && v_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
